FILE: rtl/core/tlv_record_scanner_core_assert.svh
// Assertion macros for the TLV record scanner core.
// Included by RTL files that carry concurrent assertions; no other dependency.
`ifndef TLV_RECORD_SCANNER_CORE_ASSERT_SVH
`define TLV_RECORD_SCANNER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TLVRS_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("tlvrs assertion failed");
`define TLVRS_ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
		else $error("tlvrs forbidden condition");
`else
`define TLVRS_ASSERT(lbl, clk_s, rstn_s, prop)
`define TLVRS_ASSERT_NEVER(lbl, clk_s, rstn_s, expr)
`endif

`endif

FILE: rtl/core/tlvrs_pkg.sv
// Shared types and constants for the TLV record scanner core.
// No dependencies; used by the channel interfaces and the core.
package tlvrs_pkg;

	localparam int unsigned IMAGE_BYTES_DEF = 1024;
	localparam logic [7:0]  TLV_MAGIC       = 8'h3C;
	localparam int unsigned SCAN_FLOOR      = 5;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_NEXT  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_MAGIC,
		S_TYPE,
		S_LENLO,
		S_LENHI,
		S_EVAL,
		S_READ
	} scan_state_t;

	typedef struct packed {
		logic       found;
		logic [9:0] payload_top;
		logic [9:0] payload_length;
		logic [7:0] read_value;
		logic       bad_type;
	} result_t;

endpackage

FILE: rtl/core/tlvrs_chan_if.sv
// Valid/ready channel interfaces for the TLV record scanner core.
// Depends on tlvrs_pkg.
interface tlvrs_cmd_if
	import tlvrs_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [9:0] byte_address;
	logic [7:0] byte_value;
	logic [7:0] wanted_type;

	modport source (output valid, op, byte_address, byte_value, wanted_type, input ready);
	modport sink   (input valid, op, byte_address, byte_value, wanted_type, output ready);
endinterface

interface tlvrs_rsp_if
	import tlvrs_pkg::*;
;
	logic       valid;
	logic       ready;
	logic       found;
	logic [9:0] payload_top;
	logic [9:0] payload_length;
	logic [7:0] read_value;
	logic       bad_type;

	modport source (output valid, found, payload_top, payload_length, read_value, bad_type,
		input ready);
	modport sink   (input valid, found, payload_top, payload_length, read_value, bad_type,
		output ready);
endinterface

FILE: rtl/core/tlv_record_scanner_core.sv
// TLV record scanner core: byte image memory plus a downward record scan sequencer.
// Depends on tlvrs_pkg, tlvrs_chan_if.sv and tlv_record_scanner_core_assert.svh.
//
// Usage: commands enter on cmd (valid/ready), one result per command leaves on rsp.
// Ops: write byte, start scan (find first of wanted_type), find next, read byte.
// Sequence: a write answers at the edge of acceptance (rsp.valid the cycle after);
// a read passes through the registered memory read and S_READ first. A find passes
// S_START, then steps over the image byte by byte in S_MAGIC, and for each header
// examined also passes S_TYPE, S_LENLO, S_LENHI and S_EVAL (type, two length bytes,
// check); a record of another type is skipped whole in the check state. The single
// read port of the image memory paces the scan.
// One command is in flight at a time; cmd.ready rises again once the sequencer is
// idle and the result register is empty or being drained in the same cycle.
// Reset: the image memory is swept to zero, one byte per cycle, over all IMAGE_BYTES bytes;
// cmd.ready stays low meanwhile. Scan state comes out of reset finished.
// Stall: a result waiting in the output register holds until rsp.ready; the
// next command is taken in the cycle that transaction completes.
`include "tlv_record_scanner_core_assert.svh"

module tlv_record_scanner_core
	import tlvrs_pkg::*;
#(
	parameter int unsigned IMAGE_BYTES = IMAGE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tlvrs_cmd_if.sink  cmd,
	tlvrs_rsp_if.source rsp
);

	localparam int unsigned AW = $clog2(IMAGE_BYTES);
	localparam logic [AW-1:0] TOP_ADDR = AW'(IMAGE_BYTES - 1);

	logic [7:0] image_mem [IMAGE_BYTES];
	logic [7:0] mem_rd_q;

	scan_state_t state_q, state_d;
	logic [AW-1:0] clr_cnt_q;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [4:0]    scan_type_q, scan_type_d;
	logic          scan_fin_q, scan_fin_d;
	logic [4:0]    type_q, type_d;
	logic [7:0]    lo_q, lo_d;
	logic [15:0]   len_q, len_d;
	logic          out_valid_q;
	result_t       out_q, res;
	logic          res_load;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic [AW-1:0] mem_ra;

	logic          cmd_fire;
	logic          addr_ok;
	logic          want_ok;
	logic          is_magic;
	logic          type_ok;
	logic [AW-1:0] ptr_m1;
	logic          ptr_low;
	logic          ptr_m1_low;
	logic          len_fit;
	logic [AW:0]   nxt;
	logic          nxt_low;

	assign cmd.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign addr_ok   = {7'd0, cmd.byte_address} < 17'(IMAGE_BYTES);
	assign want_ok   = (cmd.wanted_type != 8'd0) && (cmd.wanted_type[7:5] == 3'd0);
	assign is_magic  = mem_rd_q == TLV_MAGIC;
	assign type_ok   = (mem_rd_q != 8'd0) && (mem_rd_q[7:5] == 3'd0);
	assign ptr_m1    = ptr_q - AW'(1);
	assign ptr_low   = {1'b0, ptr_q} < (AW+1)'(SCAN_FLOOR);
	assign ptr_m1_low = {1'b0, ptr_m1} < (AW+1)'(SCAN_FLOOR);
	// header sits at p, so the payload may use at most p-1 bytes
	assign len_fit   = {1'b0, len_q} <= (17'(ptr_q) - 17'd1);
	// may dip to -3; top bit marks a negative pointer
	assign nxt       = {1'b0, ptr_q} - (AW+1)'(4) - (AW+1)'(len_q);
	assign nxt_low   = nxt[AW] || (nxt < (AW+1)'(SCAN_FLOOR));

	// Image memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			image_mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= image_mem[mem_ra];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == TOP_ADDR) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_fire) begin
					unique case (cmd.op)
						OP_WRITE: state_d = S_IDLE;
						OP_READ:  state_d = addr_ok ? S_READ : S_IDLE;
						OP_START: state_d = want_ok ? S_START : S_IDLE;
						OP_NEXT:  state_d = scan_fin_q ? S_IDLE : S_START;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_START: state_d = ptr_low ? S_IDLE : S_MAGIC;
			S_MAGIC: begin
				if (is_magic) state_d = S_TYPE;
				else state_d = ptr_m1_low ? S_IDLE : S_MAGIC;
			end
			S_TYPE: begin
				if (type_ok) state_d = S_LENLO;
				else state_d = ptr_m1_low ? S_IDLE : S_MAGIC;
			end
			S_LENLO: state_d = S_LENHI;
			S_LENHI: state_d = S_EVAL;
			S_EVAL: begin
				if (!len_fit) state_d = ptr_m1_low ? S_IDLE : S_MAGIC;
				else if (type_q == scan_type_q) state_d = S_IDLE;
				else state_d = nxt_low ? S_IDLE : S_MAGIC;
			end
			S_READ: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath controls and result
	always_comb begin
		mem_we      = 1'b0;
		mem_wa      = clr_cnt_q;
		mem_wd      = 8'd0;
		mem_ra      = ptr_q;
		ptr_d       = ptr_q;
		scan_type_d = scan_type_q;
		scan_fin_d  = scan_fin_q;
		type_d      = type_q;
		lo_d        = lo_q;
		len_d       = len_q;
		res_load    = 1'b0;
		res         = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (cmd_fire) begin
					unique case (cmd.op)
						OP_WRITE: begin
							mem_we   = addr_ok;
							mem_wa   = AW'(cmd.byte_address);
							mem_wd   = cmd.byte_value;
							res_load = 1'b1;
						end
						OP_READ: begin
							mem_ra   = AW'(cmd.byte_address);
							res_load = !addr_ok;
						end
						OP_START: begin
							ptr_d = TOP_ADDR;
							if (want_ok) begin
								scan_type_d = cmd.wanted_type[4:0];
								scan_fin_d  = 1'b0;
							end else begin
								scan_fin_d   = 1'b1;
								res_load     = 1'b1;
								res.bad_type = 1'b1;
							end
						end
						OP_NEXT: begin
							res_load = scan_fin_q;
						end
						default: ;
					endcase
				end
			end
			S_START: begin
				mem_ra = ptr_q;
				if (ptr_low) begin
					scan_fin_d = 1'b1;
					ptr_d      = '0;
					res_load   = 1'b1;
				end
			end
			S_MAGIC, S_TYPE: begin
				if (state_q == S_MAGIC && is_magic) begin
					mem_ra = ptr_m1;
				end else if (state_q == S_TYPE && type_ok) begin
					type_d = mem_rd_q[4:0];
					mem_ra = ptr_q - AW'(2);
				end else if (ptr_m1_low) begin
					scan_fin_d = 1'b1;
					ptr_d      = '0;
					res_load   = 1'b1;
				end else begin
					ptr_d  = ptr_m1;
					mem_ra = ptr_m1;
				end
			end
			S_LENLO: begin
				lo_d   = mem_rd_q;
				mem_ra = ptr_q - AW'(3);
			end
			S_LENHI: begin
				len_d = {mem_rd_q, lo_q};
			end
			S_EVAL: begin
				if (!len_fit) begin
					if (ptr_m1_low) begin
						scan_fin_d = 1'b1;
						ptr_d      = '0;
						res_load   = 1'b1;
					end else begin
						ptr_d  = ptr_m1;
						mem_ra = ptr_m1;
					end
				end else begin
					if (type_q == scan_type_q) begin
						res_load           = 1'b1;
						res.found          = 1'b1;
						res.payload_top    = 10'(ptr_q - AW'(4));
						res.payload_length = 10'(len_q);
					end
					if (nxt_low) begin
						scan_fin_d = 1'b1;
						ptr_d      = '0;
						res_load   = 1'b1;
					end else begin
						ptr_d  = nxt[AW-1:0];
						mem_ra = nxt[AW-1:0];
					end
				end
			end
			S_READ: begin
				res_load       = 1'b1;
				res.read_value = mem_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			ptr_q       <= TOP_ADDR;
			scan_type_q <= '0;
			scan_fin_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ptr_q       <= ptr_d;
			scan_type_q <= scan_type_d;
			scan_fin_q  <= scan_fin_d;
			if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (res_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		type_q <= type_d;
		lo_q   <= lo_d;
		len_q  <= len_d;
		if (res_load) out_q <= res;
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.found          = out_q.found;
	assign rsp.payload_top    = out_q.payload_top;
	assign rsp.payload_length = out_q.payload_length;
	assign rsp.read_value     = out_q.read_value;
	assign rsp.bad_type       = out_q.bad_type;

	`TLVRS_ASSERT_NEVER(a_no_cmd_in_clear, clk, arst_n, (state_q == S_CLEAR) && cmd.ready)
	`TLVRS_ASSERT(a_no_result_overrun, clk, arst_n, res_load |-> (!out_valid_q || rsp.ready))
	`TLVRS_ASSERT(a_ptr_in_image, clk, arst_n, ptr_q <= TOP_ADDR)
	`TLVRS_ASSERT(a_found_clean, clk, arst_n,
		(res_load && res.found) |-> (!res.bad_type && res.read_value == 8'd0))
	`TLVRS_ASSERT(a_one_result_per_cmd, clk, arst_n,
		(cmd_fire && cmd.op == OP_WRITE) |=> out_valid_q)

endmodule

FILE: dv/tb_tlv_record_scanner_core.sv
// Testbench for tlv_record_scanner_core: byte writes, reads and record scans checked
// against a cycle-free predictor of the image and scan state. Needs tlvrs_pkg, the
// channel interfaces in tlvrs_chan_if.sv and the core RTL.
`timescale 1ns / 1ps

module tb_tlv_record_scanner_core;
	import tlvrs_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int IMAGE_BYTES  = IMAGE_BYTES_DEF;
	localparam int TYPE_MIN     = 1;
	localparam int TYPE_MAX     = 31;
	localparam int DRAIN_CYCLES = 64;
	// run-time bound: room for a worst-case find on every item, with slack
	localparam int CYCLE_LIMIT  = 8_000_000;
	localparam int PRINT_CAP    = 100;

	logic clk = 1'b0;
	logic arst_n;

	tlvrs_cmd_if cmd_ch ();
	tlvrs_rsp_if rsp_ch ();

	tlv_record_scanner_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predicted image and scan state
	logic [7:0] shadow_image [IMAGE_BYTES];
	int         scan_ptr;
	logic [4:0] scan_type;
	bit         scan_done;

	result_t pending_results [$];
	int      items_sent    = 0;
	int      err_count     = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      cycle_count   = 0;

	task automatic report_mismatch(input string what, input int unsigned got_v,
		input int unsigned exp_v);
		if (err_count < PRINT_CAP) begin
			$display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got_v, exp_v);
		end
		err_count++;
	endtask

	function automatic result_t predict_result(input logic [1:0] op, input logic [9:0] addr,
		input logic [7:0] val, input logic [7:0] want);
		result_t    r;
		int         p;
		int         ln;
		logic [7:0] ty;
		bit         hit;
		r = '0;
		case (op)
			OP_WRITE: begin
				shadow_image[addr] = val;
			end
			OP_READ: begin
				r.read_value = shadow_image[addr];
			end
			default: begin
				if (op == OP_START) begin
					scan_ptr = IMAGE_BYTES - 1;
					if (want < TYPE_MIN || want > TYPE_MAX) begin
						r.bad_type = 1'b1;
						scan_done  = 1'b1;
					end else begin
						scan_type = want[4:0];
						scan_done = 1'b0;
					end
				end
				if (!scan_done) begin
					p   = (scan_ptr > IMAGE_BYTES - 1) ? IMAGE_BYTES - 1 : scan_ptr;
					hit = 1'b0;
					while (!hit && p >= int'(SCAN_FLOOR)) begin
						ty = shadow_image[p - 1];
						ln = int'({shadow_image[p - 3], shadow_image[p - 2]});
						if (shadow_image[p] != TLV_MAGIC || ty < TYPE_MIN || ty > TYPE_MAX
							|| ln > p - 1) begin
							p--;
						end else begin
							if (ty[4:0] == scan_type) begin
								hit              = 1'b1;
								r.found          = 1'b1;
								r.payload_top    = 10'(p - 4);
								r.payload_length = 10'(ln);
							end
							// matching or not, the whole record is stepped over
							p -= 4 + ln;
						end
					end
					if (hit && p >= int'(SCAN_FLOOR)) begin
						scan_ptr = p;
					end else begin
						scan_done = 1'b1;
						scan_ptr  = 0;
					end
				end
			end
		endcase
		return r;
	endfunction

	// valid stays high across back-to-back items; it only drops during a sender gap
	task automatic send_cmd(input logic [1:0] op, input logic [9:0] addr,
		input logic [7:0] val, input logic [7:0] want);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.op           <= op;
		cmd_ch.byte_address <= addr;
		cmd_ch.byte_value   <= val;
		cmd_ch.wanted_type  <= want;
		do begin
			@(negedge clk);
			taken = cmd_ch.ready;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(predict_result(op, addr, val, want));
		items_sent++;
	endtask

	task automatic write_byte(input logic [9:0] addr, input logic [7:0] val);
		send_cmd(OP_WRITE, addr, val, 8'($urandom_range(0, 255)));
	endtask

	task automatic read_byte(input logic [9:0] addr);
		send_cmd(OP_READ, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic start_scan(input logic [7:0] want);
		send_cmd(OP_START, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)), want);
	endtask

	task automatic find_next();
		send_cmd(OP_NEXT, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// header: magic at p, type below it, then length low and high bytes
	task automatic plant_record(input int p, input logic [7:0] ty, input logic [15:0] ln);
		write_byte(10'(p), TLV_MAGIC);
		write_byte(10'(p - 1), ty);
		write_byte(10'(p - 2), ln[7:0]);
		write_byte(10'(p - 3), ln[15:8]);
	endtask

	task automatic test_after_reset();
		read_byte(10'd512);
		find_next();
	endtask

	task automatic test_bad_type();
		start_scan(8'd0);
		start_scan(8'd32);
		start_scan(8'd255);
	endtask

	// two wanted records with one of another type in between, then a record at the
	// window bottom whose payload reaches the floor, then finds past the end
	task automatic test_record_walk();
		plant_record(1023, 8'd7, 16'd3);
		plant_record(1016, 8'd9, 16'd2);
		plant_record(1010, 8'd7, 16'd0);
		plant_record(9, 8'd7, 16'd8);
		start_scan(8'd7);
		repeat (4) find_next();
	endtask

	task automatic test_byte_edges();
		read_byte(10'd1023);
		write_byte(10'd0, 8'hFF);
		read_byte(10'd0);
	endtask

	task automatic test_random_mix(input int n_items);
		int         stop_at;
		int         pick;
		int         p;
		int         k;
		int         ln;
		logic [7:0] ty;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				p = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 8) : $urandom_range(5, 1023);
				if ($urandom_range(0, 6) != 0) begin
					ty = 8'($urandom_range(TYPE_MIN, TYPE_MAX));
				end else if ($urandom_range(0, 1) == 0) begin
					ty = 8'd0;
				end else begin
					ty = 8'($urandom_range(TYPE_MAX + 1, 255));
				end
				k = $urandom_range(0, 19);
				if (k < 14) begin
					ln = $urandom_range(0, 12);
				end else if (k < 17) begin
					ln = p - 1;
				end else if (k < 19) begin
					ln = p;
				end else begin
					ln = $urandom_range(0, 65535);
				end
				plant_record(p, ty, 16'(ln));
				if ($urandom_range(0, 1) == 0) begin
					start_scan(($urandom_range(0, 3) != 0) ? ty
						: 8'($urandom_range(TYPE_MIN, TYPE_MAX)));
					repeat ($urandom_range(0, 3)) find_next();
				end
			end else if (pick < 60) begin
				start_scan(($urandom_range(0, 4) != 0) ? 8'($urandom_range(TYPE_MIN, TYPE_MAX))
					: 8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 4)) find_next();
			end else if (pick < 70) begin
				find_next();
			end else if (pick < 85) begin
				read_byte(10'($urandom_range(0, 1023)));
			end else begin
				write_byte(10'($urandom_range(0, 1023)),
					($urandom_range(0, 3) == 0) ? TLV_MAGIC : 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// a transaction completes at the next rising edge when both are high at the falling one
	always @(negedge clk) begin
		result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(rsp_ch.found), 0);
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_ch.found !== exp_r.found)
					report_mismatch("found", 32'(rsp_ch.found), 32'(exp_r.found));
				if (rsp_ch.payload_top !== exp_r.payload_top)
					report_mismatch("payload_top", 32'(rsp_ch.payload_top),
						32'(exp_r.payload_top));
				if (rsp_ch.payload_length !== exp_r.payload_length)
					report_mismatch("payload_length", 32'(rsp_ch.payload_length),
						32'(exp_r.payload_length));
				if (rsp_ch.read_value !== exp_r.read_value)
					report_mismatch("read_value", 32'(rsp_ch.read_value),
						32'(exp_r.read_value));
				if (rsp_ch.bad_type !== exp_r.bad_type)
					report_mismatch("bad_type", 32'(rsp_ch.bad_type), 32'(exp_r.bad_type));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL tlv_record_scanner_core");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.op           = OP_WRITE;
		cmd_ch.byte_address = '0;
		cmd_ch.byte_value   = '0;
		cmd_ch.wanted_type  = '0;
		foreach (shadow_image[i]) shadow_image[i] = 8'h00;
		scan_ptr  = IMAGE_BYTES - 1;
		scan_type = '0;
		scan_done = 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 83;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_bad_type();
		test_record_walk();
		test_byte_edges();
		test_random_mix(183);

		send_idle_pct = 83;
		recv_idle_pct = 12;
		test_random_mix(183);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(183);

		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results still pending", 0, pending_results.size());

		if (err_count == 0) begin
			$display("PASS tlv_record_scanner_core");
		end else begin
			$display("FAIL tlv_record_scanner_core");
		end
		$finish;
	end

endmodule
